@@ rtl/bgd_pkg.sv @@
// Shared types and constants of the button gesture detector.
// Used by every module in rtl/; depends on nothing.
package bgd_pkg;

  // Field widths fixed by the interface.
  localparam int PIN_W        = 2;
  localparam int STAMP_W      = 32;
  localparam int MS_W         = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int EV_W         = 3;

  // Default channel count.
  localparam int NUM_PINS_DEF = 4;

  // A sample causes at most this many events.
  localparam int MAX_EV       = 3;

  // Event queue in front of the result port.
  localparam int EVQ_DEPTH    = 8;
  localparam int EVQ_AW       = $clog2(EVQ_DEPTH);

  // Configuration defaults.
  localparam logic [MS_W-1:0]    DEBOUNCE_RST     = 16'd50;
  localparam logic [MS_W-1:0]    LONG_PRESS_RST   = 16'd1000;
  localparam logic [STAMP_W-1:0] IDLE_RST         = 32'd10000;
  localparam logic [MS_W-1:0]    DOUBLE_CLICK_RST = 16'd400;

  typedef enum logic [EV_W-1:0] {
    EV_PRESS      = 3'd0,
    EV_RELEASE    = 3'd1,
    EV_SHORT      = 3'd2,
    EV_DOUBLE     = 3'd3,
    EV_LONG       = 3'd4,
    EV_IDLE_START = 3'd5,
    EV_IDLE_END   = 3'd6
  } ev_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE     = 2'd0,
    CFG_LONG_PRESS   = 2'd1,
    CFG_IDLE         = 2'd2,
    CFG_DOUBLE_CLICK = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [MS_W-1:0]    debounce_ms;
    logic [MS_W-1:0]    long_press_ms;
    logic [STAMP_W-1:0] idle_ms;
    logic [MS_W-1:0]    double_click_ms;
  } cfg_t;

  // One channel's entry in the state memory.
  typedef struct packed {
    logic               raw_prev;
    logic [STAMP_W-1:0] debounce_stamp;
    logic               stable_pressed;
    logic [STAMP_W-1:0] change_stamp;
    logic [STAMP_W-1:0] release_stamp;
    logic               idle_flag;
    logic               long_flag;
  } pin_state_t;

  typedef struct packed {
    logic [PIN_W-1:0] pin_res;
    ev_code_t         event_res;
    logic             last;
  } evq_entry_t;

endpackage

@@ rtl/button_gesture_detector.sv @@
// Top level of the button gesture detector: configuration registers, the
// state read-modify-write pipeline and the result queue. Uses bgd_pkg and
// bgd_state_mem, bgd_eval, bgd_evq.
//
//  Channel  | Signals                         | Direction | Handshake
//  ---------+---------------------------------+-----------+------------------
//  input    | pin, raw_level, now_ms          | in        | in_valid/in_ready
//  result   | pin_res, event_res, last        | out       | out_valid/out_ready
//  config   | cfg_wr_en, cfg_index, cfg_data  | in        | write enable only
//
// A request's state is read from the memory as it is accepted; it is evaluated
// and written back in the cycle after, and its events enter the queue at that
// edge. They leave one per cycle while out_ready is high, so the single result
// port, at up to three events per request, bounds the rate of requests.
// A request to the channel written in the previous cycle takes the forwarded
// entry. Reset is synchronous and clears state through per-entry valid bits
// at once; no clearing pass. in_ready drops while the queue lacks room for
// three more events beyond those already in flight.
module button_gesture_detector #(
  parameter int NUM_PINS = bgd_pkg::NUM_PINS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bgd_pkg::PIN_W-1:0]      pin,
  input  logic                           raw_level,
  input  logic [bgd_pkg::STAMP_W-1:0]    now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bgd_pkg::PIN_W-1:0]      pin_res,
  output logic [bgd_pkg::EV_W-1:0]       event_res,
  output logic                           last,
  input  logic                           cfg_wr_en,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bgd_pkg::*;

  localparam int ADDR_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  cfg_t               cfg;
  logic               in_acc;
  logic               pin_ok;
  logic [EVQ_AW+1:0]  reserve;

  logic               s1_valid;
  logic [ADDR_W-1:0]  s1_addr;
  logic [PIN_W-1:0]   s1_pin;
  logic               s1_raw;
  logic [STAMP_W-1:0] s1_now;

  logic               fwd_valid;
  logic [ADDR_W-1:0]  fwd_addr;
  pin_state_t         fwd_data;

  pin_state_t         mem_rd;
  pin_state_t         cur;
  pin_state_t         nxt;
  logic [1:0]         ev_n;
  ev_code_t           ev [MAX_EV];
  logic [1:0]         push_n;
  evq_entry_t         push_data [MAX_EV];
  evq_entry_t         head;
  logic [EVQ_AW:0]    evq_count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= DEBOUNCE_RST;
      cfg.long_press_ms   <= LONG_PRESS_RST;
      cfg.idle_ms         <= IDLE_RST;
      cfg.double_click_ms <= DOUBLE_CLICK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DEBOUNCE:     cfg.debounce_ms     <= cfg_data[MS_W-1:0];
        CFG_LONG_PRESS:   cfg.long_press_ms   <= cfg_data[MS_W-1:0];
        CFG_IDLE:         cfg.idle_ms         <= cfg_data[STAMP_W-1:0];
        CFG_DOUBLE_CLICK: cfg.double_click_ms <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Admission: room in the queue for this request and the one in flight.
  always_comb begin
    reserve  = (EVQ_AW+2)'(evq_count) + (s1_valid ? (EVQ_AW+2)'(MAX_EV) : '0);
    in_ready = !rst && (reserve <= (EVQ_AW+2)'(EVQ_DEPTH - MAX_EV));
    in_acc   = in_valid && in_ready;
    pin_ok   = 32'(pin) < 32'(NUM_PINS);
  end

  // Evaluation stage; channels beyond the count are dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= in_acc && pin_ok;
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr <= ADDR_W'(pin);
      s1_pin  <= pin;
      s1_raw  <= raw_level;
      s1_now  <= now_ms;
    end
    fwd_addr <= s1_addr;
    fwd_data <= nxt;
  end

  bgd_state_mem #(
    .NUM_PINS (NUM_PINS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (ADDR_W'(pin)),
    .rd_data (mem_rd),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (nxt)
  );

  // The write of the previous cycle is not yet visible in the read data.
  assign cur = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : mem_rd;

  bgd_eval u_eval (
    .cfg       (cfg),
    .cur       (cur),
    .raw_level (s1_raw),
    .now_ms    (s1_now),
    .nxt       (nxt),
    .ev_n      (ev_n),
    .ev        (ev)
  );

  // Events of this request, the final one marked.
  always_comb begin
    push_n = s1_valid ? ev_n : 2'd0;
    for (int i = 0; i < MAX_EV; i++) begin
      push_data[i].pin_res   = s1_pin;
      push_data[i].event_res = ev[i];
      push_data[i].last      = (2'(i + 1) == ev_n);
    end
  end

  bgd_evq u_evq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .count     (evq_count)
  );

  assign pin_res   = head.pin_res;
  assign event_res = head.event_res;
  assign last      = head.last;

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && cur.idle_flag) |-> !cur.stable_pressed)
    else $error("idle flag set on a pressed channel");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (evq_count > (EVQ_AW+1)'(EVQ_DEPTH - MAX_EV)) |-> !in_ready)
    else $error("request taken without queue room");

  a_fwd_follows: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> (fwd_valid && (fwd_addr == $past(s1_addr))))
    else $error("forwarding register lost a write");

endmodule

@@ rtl/bgd_state_mem.sv @@
// Per-channel state memory: one write port, one registered read port.
// Valid bits cleared by reset make unwritten entries read as zero. Uses bgd_pkg.
module bgd_state_mem #(
  parameter int NUM_PINS = bgd_pkg::NUM_PINS_DEF,
  localparam int ADDR_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ADDR_W-1:0]      rd_addr,
  output bgd_pkg::pin_state_t    rd_data,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  bgd_pkg::pin_state_t    wr_data
);
  import bgd_pkg::*;

  pin_state_t          mem [NUM_PINS];
  logic [NUM_PINS-1:0] vld;
  pin_state_t          rd_q;
  logic                rd_vld;

  // Storage array, written at most once and read once per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Entry valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  // An entry never written reads as the reset state.
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

@@ rtl/bgd_eval.sv @@
// Debounce and gesture classification of one sample against its channel state.
// Produces the updated state and up to three event codes. Uses bgd_pkg.
module bgd_eval (
  input  bgd_pkg::cfg_t                cfg,
  input  bgd_pkg::pin_state_t          cur,
  input  logic                         raw_level,
  input  logic [bgd_pkg::STAMP_W-1:0]  now_ms,
  output bgd_pkg::pin_state_t          nxt,
  output logic [1:0]                   ev_n,
  output bgd_pkg::ev_code_t            ev [bgd_pkg::MAX_EV]
);
  import bgd_pkg::*;

  logic [STAMP_W-1:0] dstamp;
  logic [STAMP_W-1:0] held;
  logic [STAMP_W-1:0] since_rel;
  logic               raw_chg;
  logic               bouncing;
  logic               pressed;
  logic               longtime;
  logic               idling;
  logic               dbl;
  ev_code_t           evs [MAX_EV+1];
  logic [2:0]         n;

  // Elapsed times, all modulo 2^32.
  always_comb begin
    raw_chg   = raw_level != cur.raw_prev;
    dstamp    = raw_chg ? now_ms : cur.debounce_stamp;
    bouncing  = (now_ms - dstamp) <= {16'b0, cfg.debounce_ms};
    pressed   = ~raw_level;
    held      = now_ms - cur.change_stamp;
    since_rel = now_ms - cur.release_stamp;
    longtime  = held >= {16'b0, cfg.long_press_ms};
    idling    = held >= cfg.idle_ms;
    dbl       = since_rel <= {16'b0, cfg.double_click_ms};
  end

  // State update and event list.
  always_comb begin
    nxt                = cur;
    nxt.raw_prev       = raw_level;
    nxt.debounce_stamp = dstamp;
    for (int i = 0; i <= MAX_EV; i++) begin
      evs[i] = EV_PRESS;
    end
    n = 3'd0;
    if (!bouncing) begin
      if (pressed == cur.stable_pressed) begin
        if (pressed) begin
          if (!cur.long_flag && longtime) begin
            nxt.long_flag = 1'b1;
            evs[0]        = EV_LONG;
            n             = 3'd1;
          end
        end else if (!cur.idle_flag && idling) begin
          nxt.idle_flag = 1'b1;
          evs[0]        = EV_IDLE_START;
          n             = 3'd1;
        end
      end else begin
        nxt.long_flag    = 1'b0;
        nxt.change_stamp = now_ms;
        if (pressed) begin
          evs[0] = EV_PRESS;
          n      = 3'd1;
        end else begin
          evs[0] = EV_RELEASE;
          n      = 3'd1;
          if (!longtime) begin
            evs[1] = EV_SHORT;
            n      = 3'd2;
            if (dbl) begin
              evs[2] = EV_DOUBLE;
              n      = 3'd3;
            end
            nxt.release_stamp = now_ms;
          end
        end
        if (cur.idle_flag) begin
          nxt.idle_flag = 1'b0;
          evs[n[1:0]]   = EV_IDLE_END;
          n             = n + 3'd1;
        end
        nxt.stable_pressed = pressed;
      end
    end
  end

  // Only the first three events are reported.
  always_comb begin
    ev_n = (n > 3'd3) ? 2'd3 : n[1:0];
    for (int i = 0; i < MAX_EV; i++) begin
      ev[i] = evs[i];
    end
  end

endmodule

@@ rtl/bgd_evq.sv @@
// Event queue between the evaluation stage and the result port.
// Takes up to three events a cycle, gives one while out_ready is high. Uses bgd_pkg.
module bgd_evq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                push_n,
  input  bgd_pkg::evq_entry_t       push_data [bgd_pkg::MAX_EV],
  output logic                      out_valid,
  input  logic                      out_ready,
  output bgd_pkg::evq_entry_t       head,
  output logic [bgd_pkg::EVQ_AW:0]  count
);
  import bgd_pkg::*;

  evq_entry_t        q [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wr_ptr;
  logic [EVQ_AW-1:0] rd_ptr;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign head      = q[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_EV; i++) begin
      if (2'(i) < push_n) begin
        q[wr_ptr + EVQ_AW'(i)] <= push_data[i];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + EVQ_AW'(push_n);
      rd_ptr <= rd_ptr + EVQ_AW'(pop);
      count  <= count + (EVQ_AW+1)'(push_n) - (EVQ_AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (EVQ_AW+1)'(EVQ_DEPTH))
    else $error("event queue overflow");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (count + (EVQ_AW+1)'(push_n)) <= (EVQ_AW+1)'(EVQ_DEPTH))
    else $error("event push into a full queue");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (count == '0))
    else $error("event queue not empty after reset");

endmodule

@@ dv/tb_button_gesture_detector.sv @@
// Self-checking testbench for button_gesture_detector: directed and random sample
// requests, random stalls on both channels, an in-order event predictor.
// Depends on bgd_pkg and the RTL in rtl/.
module tb_button_gesture_detector;
  import bgd_pkg::*;

  localparam int NUM_CH        = NUM_PINS_DEF;
  localparam int DIRECTED      = 21;
  localparam int RANDOM_ITEMS  = 445;
  localparam int PHASES        = 7;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [PIN_W-1:0] pin;
    ev_code_t         code;
    logic             last;
  } gesture_event_t;

  // Per-channel debounce and click classification, plus the queue of events
  // that the block still owes.
  class gesture_predictor;
    logic [MS_W-1:0]    debounce_ms;
    logic [MS_W-1:0]    long_press_ms;
    logic [STAMP_W-1:0] idle_ms;
    logic [MS_W-1:0]    double_click_ms;
    logic               level_seen[NUM_CH];
    logic [STAMP_W-1:0] bounce_at[NUM_CH];
    logic               held_down[NUM_CH];
    logic [STAMP_W-1:0] level_since[NUM_CH];
    logic [STAMP_W-1:0] last_click_at[NUM_CH];
    logic               idle_seen[NUM_CH];
    logic               long_seen[NUM_CH];
    gesture_event_t     pending_events[$];
    int                 errors;

    function new();
      debounce_ms     = DEBOUNCE_RST;
      long_press_ms   = LONG_PRESS_RST;
      idle_ms         = IDLE_RST;
      double_click_ms = DOUBLE_CLICK_RST;
      errors          = 0;
      for (int i = 0; i < NUM_CH; i++) begin
        level_seen[i]    = 1'b0;
        bounce_at[i]     = '0;
        held_down[i]     = 1'b0;
        level_since[i]   = '0;
        last_click_at[i] = '0;
        idle_seen[i]     = 1'b0;
        long_seen[i]     = 1'b0;
      end
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_DEBOUNCE:     debounce_ms     = value[MS_W-1:0];
        CFG_LONG_PRESS:   long_press_ms   = value[MS_W-1:0];
        CFG_IDLE:         idle_ms         = value;
        CFG_DOUBLE_CLICK: double_click_ms = value[MS_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    // Work out the events of one accepted sample request.
    function void note_sample(logic [PIN_W-1:0] p, logic raw, logic [STAMP_W-1:0] now);
      logic               pressed;
      logic [STAMP_W-1:0] since_bounce;
      logic [STAMP_W-1:0] held;
      logic [STAMP_W-1:0] since_click;
      logic               long_reached;
      logic               idle_reached;
      ev_code_t           evs[$];
      if (p >= NUM_CH) return;
      if (raw != level_seen[p]) bounce_at[p] = now;
      level_seen[p] = raw;
      since_bounce = now - bounce_at[p];
      // Still bouncing: the level has not been steady long enough.
      if (since_bounce <= {16'd0, debounce_ms}) return;
      pressed      = ~raw;
      held         = now - level_since[p];
      long_reached = held >= {16'd0, long_press_ms};
      idle_reached = held >= idle_ms;
      if (pressed == held_down[p]) begin
        // Steady level: long press while held, idle start while released.
        if (pressed && !long_seen[p] && long_reached) begin
          long_seen[p] = 1'b1;
          evs.push_back(EV_LONG);
        end else if (!pressed && !idle_seen[p] && idle_reached) begin
          idle_seen[p] = 1'b1;
          evs.push_back(EV_IDLE_START);
        end
      end else begin
        long_seen[p]   = 1'b0;
        level_since[p] = now;
        if (pressed) begin
          evs.push_back(EV_PRESS);
        end else begin
          evs.push_back(EV_RELEASE);
          if (!long_reached) begin
            evs.push_back(EV_SHORT);
            since_click = now - last_click_at[p];
            if (since_click <= {16'd0, double_click_ms}) evs.push_back(EV_DOUBLE);
            last_click_at[p] = now;
          end
        end
        if (idle_seen[p]) begin
          idle_seen[p] = 1'b0;
          evs.push_back(EV_IDLE_END);
        end
        held_down[p] = pressed;
      end
      foreach (evs[i])
        pending_events.push_back('{pin: p, code: evs[i], last: (i == evs.size() - 1)});
    endfunction

    // Compare one accepted event with the oldest one owed.
    function void check_event(logic [PIN_W-1:0] p, logic [EV_W-1:0] ev, logic l);
      gesture_event_t want;
      if (pending_events.size() == 0) begin
        $error("unexpected event: pin_res %0d event_res %0d last %0d", p, ev, l);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (p !== want.pin) begin
        $error("pin_res mismatch: expected %0d actual %0d", want.pin, p);
        errors++;
      end
      if (ev !== want.code) begin
        $error("event_res mismatch: expected %0d actual %0d", want.code, ev);
        errors++;
      end
      if (l !== want.last) begin
        $error("last mismatch: expected %0d actual %0d", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [PIN_W-1:0]      pin       = '0;
  logic                  raw_level = 1'b0;
  logic [STAMP_W-1:0]    now_ms    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [PIN_W-1:0]      pin_res;
  logic [EV_W-1:0]       event_res;
  logic                  last;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  gesture_predictor   predictor = new();
  logic [STAMP_W-1:0] pin_clock[NUM_CH];
  logic               calm = 1'b0;
  int                 samples_sent = 0;
  int unsigned        cycles = 0;

  button_gesture_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pin       (pin),
    .raw_level (raw_level),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pin_res   (pin_res),
    .event_res (event_res),
    .last      (last),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Check every event accepted on the result channel.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) predictor.check_event(pin_res, event_res, last);
  end

  // Result side back-pressure in random bursts, none in the calm part.
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  // Drive one sample request and wait for it to be taken.
  task automatic send(input logic [PIN_W-1:0] p, input logic raw, input logic [STAMP_W-1:0] now);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid  = 1'b1;
    pin       = p;
    raw_level = raw;
    now_ms    = now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predictor.note_sample(p, raw, now);
    samples_sent++;
  endtask

  // Stop requests, let every owed event drain and the pipeline empty.
  task automatic go_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    predictor.set_register(idx, data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Upper bits of the 16-bit registers carry junk that must be dropped.
  task automatic apply_config(input logic [MS_W-1:0] deb, input logic [MS_W-1:0] lng,
                              input logic [STAMP_W-1:0] idl, input logic [MS_W-1:0] dbl);
    go_quiet();
    write_register(CFG_DEBOUNCE, {16'($urandom), deb});
    write_register(CFG_LONG_PRESS, {16'($urandom), lng});
    write_register(CFG_IDLE, idl);
    write_register(CFG_DOUBLE_CLICK, {16'($urandom), dbl});
  endtask

  // A span just under, at, just over or well around a threshold.
  function automatic logic [STAMP_W-1:0] pick_span(input logic [STAMP_W-1:0] limit);
    case ($urandom_range(0, 4))
      0:       return limit - 1;
      1:       return limit;
      2:       return limit + 1;
      3:       return $urandom_range(0, limit);
      default: return limit + $urandom_range(0, limit);
    endcase
  endfunction

  // Bring a channel to a steady level, sometimes after some bouncing, and
  // sometimes probing the exact debounce boundary first.
  task automatic settle(input logic [PIN_W-1:0] p, input logic raw);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        pin_clock[p] += $urandom_range(0, predictor.debounce_ms);
        send(p, 1'($urandom_range(0, 1)), pin_clock[p]);
      end
    end
    pin_clock[p] += $urandom_range(1, 40);
    send(p, raw, pin_clock[p]);
    if ($urandom_range(0, 3) == 0) begin
      pin_clock[p] += {16'd0, predictor.debounce_ms};
      send(p, raw, pin_clock[p]);
      pin_clock[p] += 1;
    end else begin
      pin_clock[p] += {16'd0, predictor.debounce_ms} + 1 + $urandom_range(0, 3);
    end
    send(p, raw, pin_clock[p]);
  endtask

  // One random gesture: noise, a quick double click, or a press and release
  // timed around the long press, idle and double click thresholds.
  task automatic play_gesture();
    logic [PIN_W-1:0]   p;
    logic [STAMP_W-1:0] brief;
    p = PIN_W'($urandom_range(0, NUM_CH - 1));
    case ($urandom_range(0, 9))
      0: begin
        send(2'($urandom_range(0, NUM_CH - 1)), 1'($urandom_range(0, 1)), $urandom);
      end
      1, 2, 3: begin
        brief = $urandom_range(0, predictor.double_click_ms / 4);
        repeat (2) begin
          settle(p, 1'b0);
          pin_clock[p] += brief;
          settle(p, 1'b1);
          pin_clock[p] += brief;
        end
      end
      default: begin
        settle(p, 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          pin_clock[p] += pick_span({16'd0, predictor.long_press_ms});
          send(p, 1'b0, pin_clock[p]);
        end
        pin_clock[p] += pick_span({16'd0, predictor.long_press_ms});
        settle(p, 1'b1);
        if ($urandom_range(0, 1) == 0) begin
          pin_clock[p] += pick_span(predictor.idle_ms);
          send(p, 1'b1, pin_clock[p]);
        end else begin
          pin_clock[p] += pick_span({16'd0, predictor.double_click_ms});
        end
      end
    endcase
  endtask

  initial begin
    foreach (pin_clock[i]) pin_clock[i] = $urandom;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part with the reset settings. Channel 0: bouncing sample,
    // press, short click that counts as a double click against time zero,
    // a real double click, long press, idle start and the idle end on press.
    send(2'd0, 1'b0, 32'd10);
    send(2'd0, 1'b0, 32'd100);
    send(2'd0, 1'b1, 32'd150);
    send(2'd0, 1'b1, 32'd201);
    send(2'd0, 1'b0, 32'd300);
    send(2'd0, 1'b0, 32'd351);
    send(2'd0, 1'b1, 32'd400);
    send(2'd0, 1'b1, 32'd451);
    send(2'd0, 1'b0, 32'd500);
    send(2'd0, 1'b0, 32'd551);
    send(2'd0, 1'b0, 32'd1551);
    send(2'd0, 1'b0, 32'd2000);
    send(2'd0, 1'b1, 32'd2100);
    send(2'd0, 1'b1, 32'd2151);
    send(2'd0, 1'b1, 32'd12151);
    send(2'd0, 1'b1, 32'd13000);
    send(2'd0, 1'b0, 32'd13100);
    send(2'd0, 1'b0, 32'd13151);
    // Channel 3 across the timestamp wrap.
    send(2'd3, 1'b0, 32'hFFFF_FFF0);
    send(2'd3, 1'b1, 32'hFFFF_FFFF);
    send(2'd3, 1'b1, 32'h0000_0040);

    // Random part, one register setting per phase, extremes included.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1:       apply_config(16'd0, 16'd0, 32'd0, 16'd0);
        3:       apply_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        4:       apply_config(16'd0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        5:       apply_config(16'hFFFF, 16'd0, 32'd0, 16'd0);
        default: apply_config(16'($urandom_range(0, 30)), 16'($urandom_range(40, 400)),
                              $urandom_range(300, 3000), 16'($urandom_range(20, 400)));
      endcase
      calm = (ph == PHASES - 1);
      while (samples_sent < DIRECTED + (ph + 1) * RANDOM_ITEMS / PHASES) play_gesture();
    end

    go_quiet();
    if (predictor.errors == 0 && predictor.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
